>>> sv/uidt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uidt_pkg
// Types and constants shared by the card-ID slot table modules.
// ----------------------------------------------------------------------------
package uidt_pkg;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [7:0] EMPTY_MARK = 8'hFF;
    localparam logic [7:0] NO_SLOT    = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] card_id;
        logic [7:0]  access_type;
    } uidt_in_t;

    typedef struct packed {
        logic [7:0] slot_index;
        logic       success;
    } uidt_out_t;

    // Verdict of the slot comparator on one stored word
    typedef struct packed {
        logic match;
        logic empty;
    } uidt_cmp_t;

endpackage : uidt_pkg
`default_nettype wire

>>> sv/uidt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uidt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module uidt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : uidt_ram
`default_nettype wire

>>> sv/uidt_slot_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uidt_slot_cmp
// Shared slot comparator: flags an empty slot and a full-ID match.
// ----------------------------------------------------------------------------
module uidt_slot_cmp (
    input  wire logic [31:0]        slot_word,
    input  wire logic [31:0]        card_id,
    output uidt_pkg::uidt_cmp_t     verdict
);
    import uidt_pkg::*;

    always_comb begin
        verdict.empty = (slot_word[7:0] == EMPTY_MARK);
        // empty slots never match, even an ID with byte 0 of all ones
        verdict.match = !verdict.empty && (slot_word == card_id);
    end

endmodule : uidt_slot_cmp
`default_nettype wire

>>> sv/uid_slot_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uid_slot_table_top
// Card-ID slot table with lookup, insert and delete, scanned one slot a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request beat (kind, card_id, access_type).
//   m_valid/m_ready/m_data carry one result beat (slot_index, success).
//   s_ready is high only while the block is idle; one request is in flight.
//   After acceptance the sequencer reads the ID RAM one slot per cycle
//   through the single comparator: the scan over all SLOT_COUNT slots
//   with its registered read, a decide state that writes the table on an
//   insert or delete, then the result beat. The block returns to idle once
//   the result is taken, and only then accepts the next request.
//   Reset clears the per-slot valid flags, so every slot reads as erased
//   (all ones) right away; no clearing pass is needed.
//   When the receiver stalls, the result beat holds in its output register
//   and no new request is accepted until it is taken.
// ----------------------------------------------------------------------------
module uid_slot_table_top #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire uidt_pkg::uidt_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output uidt_pkg::uidt_out_t      m_data
);
    import uidt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]            state_reg,      state_next;
    uidt_in_t              req_reg,        req_next;
    logic [CNT_W-1:0]      rd_cnt_reg,     rd_cnt_next;
    logic                  dv_reg,         dv_next;
    logic [IDX_W-1:0]      di_reg,         di_next;
    logic                  vbit_reg,       vbit_next;
    logic                  hit_found_reg,  hit_found_next;
    logic [IDX_W-1:0]      hit_idx_reg,    hit_idx_next;
    logic [31:0]           hit_word_reg,   hit_word_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg,   free_idx_next;
    logic [SLOT_COUNT-1:0] valid_reg,      valid_next;
    uidt_out_t             res_reg,        res_next;
    logic                  m_valid_reg,    m_valid_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [31:0]           id_rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [31:0]           wr_word;
    logic [31:0]           scan_word;
    uidt_cmp_t             verdict;
    logic                  s_accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = res_reg;

    assign rd_en   = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(SLOT_COUNT));
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    // a slot never written reads as erased
    assign scan_word = vbit_reg ? id_rd_data : 32'hFFFF_FFFF;

    uidt_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_COUNT)
    ) u_id_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (id_rd_data)
    );

    // type byte is kept per slot; no operation reads it back
    uidt_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_COUNT)
    ) u_type_ram (
        .clk     (aclk),
        .wr_en   (wr_en && (req_reg.kind == KIND_INSERT)),
        .wr_addr (wr_addr),
        .wr_data (req_reg.access_type),
        .rd_en   (1'b0),
        .rd_addr (wr_addr),
        .rd_data ()
    );

    uidt_slot_cmp u_cmp (
        .slot_word (scan_word),
        .card_id   (req_reg.card_id),
        .verdict   (verdict)
    );

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        rd_cnt_next     = rd_cnt_reg;
        dv_next         = 1'b0;
        di_next         = rd_addr;
        vbit_next       = valid_reg[rd_addr];
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        wr_en           = 1'b0;
        wr_addr         = free_idx_reg;
        wr_word         = req_reg.card_id;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next        = s_data;
                    rd_cnt_next     = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    dv_next     = 1'b1;
                end
                if (dv_reg) begin
                    // keep the lowest hit and the lowest free slot
                    if (verdict.match && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = di_reg;
                        hit_word_next  = scan_word;
                    end
                    if (verdict.empty && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = di_reg;
                    end
                    if (di_reg == IDX_W'(SLOT_COUNT - 1)) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                res_next.slot_index = NO_SLOT;
                res_next.success    = 1'b0;
                case (req_reg.kind)
                    KIND_LOOKUP: begin
                        if (hit_found_reg) begin
                            res_next.slot_index = 8'(hit_idx_reg);
                            res_next.success    = 1'b1;
                        end
                    end
                    KIND_INSERT: begin
                        if (!hit_found_reg && free_found_reg) begin
                            wr_en                 = 1'b1;
                            wr_addr               = free_idx_reg;
                            wr_word               = req_reg.card_id;
                            valid_next[free_idx_reg] = 1'b1;
                            res_next.slot_index   = 8'(free_idx_reg);
                            res_next.success      = 1'b1;
                        end
                    end
                    KIND_DELETE: begin
                        if (hit_found_reg) begin
                            // mark byte 0 erased, keep the upper bytes
                            wr_en                = 1'b1;
                            wr_addr              = hit_idx_reg;
                            wr_word              = {hit_word_reg[31:8], EMPTY_MARK};
                            valid_next[hit_idx_reg] = 1'b1;
                            res_next.slot_index  = 8'(hit_idx_reg);
                            res_next.success     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                m_valid_next = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            dv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            dv_reg      <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        rd_cnt_reg     <= rd_cnt_next;
        di_reg         <= di_next;
        vbit_reg       <= vbit_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_word_reg   <= hit_word_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result beat is pending");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_SCAN) && !s_ready)
        else $error("accepted request did not start a scan");

    a_fail_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.success) |-> (m_data.slot_index == NO_SLOT))
        else $error("failed operation reports a slot index");

    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.success) |-> (m_data.slot_index < 8'(SLOT_COUNT)))
        else $error("reported slot index beyond the table");

    a_write_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_valid && (state_reg == ST_RESP))
        else $error("table write not followed by a result beat");

endmodule : uid_slot_table_top
`default_nettype wire
